/* src/skmt_pkg.sv */
// ----------------------------------------------------------------------------
// skmt_pkg
// Shared record type, opcodes, status codes and controller states for the
// sorted keyed merge table.
// ----------------------------------------------------------------------------
package skmt_pkg;

    localparam int KEY_W    = 31;
    localparam int AMOUNT_W = 31;
    localparam int TAG_W    = 32;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;

    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [AMOUNT_W-1:0] amount;
        logic [TAG_W-1:0]    tag;
    } rec_t;

    localparam logic [OP_W-1:0] OP_MERGE = 2'd0;
    localparam logic [OP_W-1:0] OP_DUMP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_MERGED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_DROPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_ENTRY    = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd5;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_MERGE,
        FSM_DUMP
    } fsm_t;

endpackage

/* src/skmt_cell.sv */
// ----------------------------------------------------------------------------
// skmt_cell
// One slot of the record chain. On each shift it takes the record of its
// upper neighbor, so the chain rotates toward the head cell.
// ----------------------------------------------------------------------------
module skmt_cell (
    input  logic          clk,
    input  logic          shift,
    input  skmt_pkg::rec_t rec_in,
    output skmt_pkg::rec_t rec_out
);
    import skmt_pkg::*;

    rec_t rec_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            rec_reg <= rec_in;
        end
    end

    assign rec_out = rec_reg;

endmodule

/* src/skmt_ctrl.sv */
// ----------------------------------------------------------------------------
// skmt_ctrl
// Sequencer at the chain head. While the chain rotates one full turn it looks
// at the head record each cycle the output is not stalled, merges or inserts
// the pending record or emits each held entry, and drives the output register.
// ----------------------------------------------------------------------------
module skmt_ctrl #(
    parameter int CAPACITY = 64,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [skmt_pkg::OP_W-1:0]     opcode,
    input  skmt_pkg::rec_t                in_rec,
    input  skmt_pkg::rec_t                head,
    output logic                          shift,
    output skmt_pkg::rec_t                wb,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [skmt_pkg::STATUS_W-1:0] status,
    output skmt_pkg::rec_t                out_rec,
    output logic [CNT_W-1:0]              entry_count,
    output logic                          last
);
    import skmt_pkg::*;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);

    fsm_t                state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    rec_t                new_reg, new_next;
    rec_t                carry_reg, carry_next;
    logic                done_reg, done_next;
    logic                ins_reg, ins_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    rec_t                out_rec_reg, out_rec_next;
    logic [CNT_W-1:0]    cnt_out_reg, cnt_out_next;
    logic                last_reg, last_next;

    logic                adv;
    logic                accept;
    logic                at_last;

    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != FSM_IDLE) || !adv;
    assign accept   = in_valid && !in_stall;
    assign at_last  = (idx_reg == IDX_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (accept && opcode == OP_MERGE && count_reg != CNT_FULL)
                begin
                    state_next = FSM_MERGE;
                end
                else if (accept && opcode == OP_DUMP && count_reg != '0)
                begin
                    state_next = FSM_DUMP;
                end
            end
            FSM_MERGE, FSM_DUMP:
            begin
                if (adv && at_last)
                begin
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        logic [AMOUNT_W:0]   sum;
        logic [AMOUNT_W-1:0] sat_amount;
        logic                occ;
        logic                at_end;
        logic                emit;
        logic [STATUS_W-1:0] e_status;
        rec_t                e_rec;
        logic [CNT_W-1:0]    e_cnt;
        logic                e_last;
        logic                ins_now;

        sum        = {1'b0, head.amount} + {1'b0, new_reg.amount};
        sat_amount = sum[AMOUNT_W] ? '1 : sum[AMOUNT_W-1:0];
        occ        = CNT_W'(idx_reg) < count_reg;
        at_end     = CNT_W'(idx_reg) == count_reg;

        emit     = 1'b0;
        e_status = STAT_EMPTY;
        e_rec    = '0;
        e_cnt    = count_reg;
        e_last   = 1'b1;
        ins_now  = ins_reg;

        idx_next    = idx_reg;
        count_next  = count_reg;
        new_next    = new_reg;
        carry_next  = carry_reg;
        done_next   = done_reg;
        ins_next    = ins_reg;
        wb          = head;
        shift       = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    case (opcode)
                        OP_MERGE:
                        begin
                            if (count_reg == CNT_FULL)
                            begin
                                emit     = 1'b1;
                                e_status = STAT_DROPPED;
                                e_rec    = in_rec;
                            end
                            else
                            begin
                                new_next  = in_rec;
                                idx_next  = '0;
                                done_next = 1'b0;
                                ins_next  = 1'b0;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                idx_next = '0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            emit       = 1'b1;
                            e_cnt      = '0;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            FSM_MERGE:
            begin
                if (adv)
                begin
                    shift    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    if (occ)
                    begin
                        if (done_reg)
                        begin
                            // ripple the displaced record up one slot
                            if (ins_reg)
                            begin
                                wb         = carry_reg;
                                carry_next = head;
                            end
                        end
                        else if (head.key == new_reg.key)
                        begin
                            wb.amount = sat_amount;
                            done_next = 1'b1;
                            emit      = 1'b1;
                            e_status  = (head.tag != new_reg.tag) ? STAT_MISMATCH
                                                                  : STAT_MERGED;
                            e_rec     = head;
                            e_rec.amount = sat_amount;
                        end
                        else if (head.key > new_reg.key)
                        begin
                            wb         = new_reg;
                            carry_next = head;
                            done_next  = 1'b1;
                            ins_next   = 1'b1;
                            ins_now    = 1'b1;
                            emit       = 1'b1;
                            e_status   = STAT_INSERTED;
                            e_rec      = new_reg;
                            e_cnt      = count_reg + CNT_W'(1);
                        end
                    end
                    else if (at_end)
                    begin
                        if (!done_reg)
                        begin
                            wb        = new_reg;
                            done_next = 1'b1;
                            ins_next  = 1'b1;
                            ins_now   = 1'b1;
                            emit      = 1'b1;
                            e_status  = STAT_INSERTED;
                            e_rec     = new_reg;
                            e_cnt     = count_reg + CNT_W'(1);
                        end
                        else if (ins_reg)
                        begin
                            wb = carry_reg;
                        end
                    end
                    if (at_last && ins_now)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            FSM_DUMP:
            begin
                if (adv)
                begin
                    shift    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                    if (occ)
                    begin
                        emit     = 1'b1;
                        e_status = STAT_ENTRY;
                        e_rec    = head;
                        e_last   = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
                    end
                end
            end
            default:
            begin
                shift = 1'b0;
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        out_rec_next   = out_rec_reg;
        cnt_out_next   = cnt_out_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            status_next    = e_status;
            out_rec_next   = e_rec;
            cnt_out_next   = e_cnt;
            last_next      = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
            ins_reg       <= ins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg     <= new_next;
        carry_reg   <= carry_next;
        status_reg  <= status_next;
        out_rec_reg <= out_rec_next;
        cnt_out_reg <= cnt_out_next;
        last_reg    <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_rec     = out_rec_reg;
    assign entry_count = cnt_out_reg;
    assign last        = last_reg;

endmodule

/* src/sorted_keyed_merge_table_top.sv */
// ----------------------------------------------------------------------------
// sorted_keyed_merge_table_top
// Sorted table of (key, amount, tag) records with merge, dump and clear.
// ----------------------------------------------------------------------------
// The table is a ring of CAPACITY record cells that rotates one slot per
// cycle past a sequencer at the head. A merge or dump transfer accepts the
// item and then rotates the chain one full turn, during which the sequencer
// merges or inserts the record and ripples later records up a slot, or
// emits each held entry in key order. Clear, a dump of an empty table, a
// merge into a full table and an unused opcode finish in the accept cycle.
// One item is in work at a time; a result that waits in the output
// register holds the chain until it is taken.
// ----------------------------------------------------------------------------
module sorted_keyed_merge_table_top #(
    parameter int CAPACITY = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      opcode,
    input  logic [30:0]                     part_key,
    input  logic [30:0]                     amount,
    input  logic [31:0]                     name_tag,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [30:0]                     out_key,
    output logic [30:0]                     out_amount,
    output logic [31:0]                     out_tag,
    output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
    output logic                            last
);
    import skmt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    rec_t cell_q [CAPACITY];
    rec_t in_rec;
    rec_t wb;
    rec_t out_rec;
    logic shift;

    assign in_rec.key    = part_key;
    assign in_rec.amount = amount;
    assign in_rec.tag    = name_tag;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == CAPACITY - 1)
            begin : g_tail
                skmt_cell u_cell (
                    .clk     (clk),
                    .shift   (shift),
                    .rec_in  (wb),
                    .rec_out (cell_q[gi])
                );
            end
            else
            begin : g_body
                skmt_cell u_cell (
                    .clk     (clk),
                    .shift   (shift),
                    .rec_in  (cell_q[gi+1]),
                    .rec_out (cell_q[gi])
                );
            end
        end
    endgenerate

    skmt_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .in_rec      (in_rec),
        .head        (cell_q[0]),
        .shift       (shift),
        .wb          (wb),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_rec     (out_rec),
        .entry_count (entry_count),
        .last        (last)
    );

    assign out_key    = out_rec.key;
    assign out_amount = out_rec.amount;
    assign out_tag    = out_rec.tag;

endmodule

/* src/skmt_checker.sv */
// ----------------------------------------------------------------------------
// skmt_checker
// Port-level checks for the sorted keyed merge table, bound to the top level.
// ----------------------------------------------------------------------------
module skmt_checker #(
    parameter int CAPACITY = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [1:0]                    opcode,
    input logic [30:0]                   part_key,
    input logic [30:0]                   amount,
    input logic [31:0]                   name_tag,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [2:0]                    status,
    input logic [30:0]                   out_key,
    input logic [30:0]                   out_amount,
    input logic [31:0]                   out_tag,
    input logic [$clog2(CAPACITY+1)-1:0] entry_count,
    input logic                          last
);
    import skmt_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // a stalled result stays valid with status, key, amount, count and last held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(out_key)
            && $stable(out_amount) && $stable(entry_count) && $stable(last))
        else $error("stalled result changed");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> entry_count == '0 && last
            && out_key == '0 && out_amount == '0 && out_tag == '0)
        else $error("empty result carries data");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_INSERTED || status == STAT_MERGED
            || status == STAT_MISMATCH || status == STAT_DROPPED) |-> last)
        else $error("single result without last");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_DROPPED |-> entry_count == CNT_W'(CAPACITY))
        else $error("record dropped while table not full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_INSERTED |->
            entry_count != '0 && entry_count <= CNT_W'(CAPACITY))
        else $error("insert reported bad entry count");

endmodule

bind sorted_keyed_merge_table_top skmt_checker #(.CAPACITY(CAPACITY)) u_skmt_checker (.*);
